>>> sv/bcm_pkg.sv
// Shared types and constants for the battery charge monitor.
// Holds field widths, reset values, status and register codes, the controller
// states and the command and status structs between controller and datapath.
`timescale 1ns / 1ps

package bcm_pkg;

  // Field and datapath widths
  localparam int ADC_W       = 10;
  localparam int SUM_W       = 20;
  localparam int GAIN_W      = 24;
  localparam int GAIN_HALF_W = 12;
  localparam int MUL_P_W     = 32;
  localparam int PROD_W      = 44;
  localparam int FRAC_W      = 16;
  localparam int MV_W        = 16;
  localparam int PCT_W       = 7;
  localparam int IDX_W       = 4;
  localparam int NUM_W       = 28;
  localparam int DEN_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;

  // Fixed thresholds and register reset values
  localparam logic [MV_W-1:0]   FULL_CHARGE_MV = 16'd12700;
  localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
  localparam logic [GAIN_W-1:0] MV_GAIN_RESET  = 24'd908000;
  localparam logic [PCT_W-1:0]  LOW_PCT_RESET  = 7'd20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MV_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT = 1'd1;

  typedef enum logic [1:0] {
    ST_ONLINE      = 2'd0,
    ST_ON_BATTERY  = 2'd1,
    ST_LOW_BATTERY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_LO,
    S_MUL_HI,
    S_AVG_DIV,
    S_AVG_WAIT,
    S_LOOKUP,
    S_SCAN,
    S_SEG_MUL,
    S_SEG_DIV,
    S_SEG_WAIT,
    S_FINISH
  } bcm_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul_lo;
    logic mul_hi;
    logic avg_start;
    logic avg_store;
    logic scan_init;
    logic scan_step;
    logic seg_latch;
    logic interp_mul;
    logic interp_start;
    logic interp_store;
    logic set_full;
    logic set_miss;
    logic out_load;
  } bcm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_table;
    logic count_full;
    logic above_full;
    logic hit;
    logic scan_last;
    logic div_busy;
  } bcm_stat_t;

endpackage

>>> sv/bcm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Shared by the averaging and the interpolation steps; uses bcm_pkg.
`timescale 1ns / 1ps

module bcm_div import bcm_pkg::*; #(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  // Shift in the next numerator bit and try a subtraction
  always_comb begin
    rem_sh  = {rem, quo[NW-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW - 1);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient, numerator bits shifted out at the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

>>> sv/bcm_dp.sv
// Datapath: configuration registers, breakpoint table, sample accumulator,
// shared multiplier, segment scan and result registers. Uses bcm_pkg, bcm_div.
`timescale 1ns / 1ps

module bcm_dp import bcm_pkg::*; #(
  parameter int SAMPLES  = 16,
  parameter int SEGMENTS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bcm_cmd_t              cmd,
  output bcm_stat_t             stat,
  input  logic                  op,
  input  logic                  mains_lost,
  input  logic                  measure_enable,
  input  logic [ADC_W-1:0]      adc_sample,
  input  logic [IDX_W-1:0]      table_index,
  input  logic [MV_W-1:0]       table_mv,
  input  logic [PCT_W-1:0]      table_percent,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [1:0]            status,
  output logic [PCT_W-1:0]      charge_percent,
  output logic                  charge_valid,
  output logic [MV_W-1:0]       average_mv
);

  localparam int DEPTH = SEGMENTS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int IXW   = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic [GAIN_W-1:0] mv_gain;
  logic [PCT_W-1:0]  low_pct;

  logic [MV_W-1:0]  bp_mv  [DEPTH];
  logic [PCT_W-1:0] bp_pct [DEPTH];
  logic [IXW-1:0]   tix_ext;
  logic             tix_ok;

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] sample_count;
  logic [MV_W-1:0]  average;
  logic             mains_r;

  logic [SUM_W-1:0]       mul_a;
  logic [GAIN_HALF_W-1:0] mul_b;
  logic [MUL_P_W-1:0]     mul_p;
  logic [MUL_P_W-1:0]     p0;
  logic [MUL_P_W-1:0]     p1;
  logic [PROD_W-1:0]      avg_prod;

  logic [AW-1:0]    scan_idx;
  logic [MV_W-1:0]  prev_mv;
  logic [PCT_W-1:0] prev_pct;
  logic [MV_W-1:0]  cur_mv;
  logic [PCT_W-1:0] cur_pct;

  logic [MV_W-1:0]  seg_off;
  logic [MV_W-1:0]  seg_d;
  logic [PCT_W-1:0] seg_c0;
  logic [PCT_W-1:0] seg_delta;
  logic             seg_up;

  logic [NUM_W-1:0] interp_num;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_start;
  logic             div_busy;
  logic [NUM_W-1:0] div_q;

  logic [PCT_W:0]   pct_sum;
  logic [PCT_W-1:0] pct_interp;
  logic [PCT_W-1:0] pct_r;
  logic             valid_r;
  status_t          st_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_gain <= MV_GAIN_RESET;
      low_pct <= LOW_PCT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MV_GAIN: mv_gain <= cfg_data[GAIN_W-1:0];
        CFG_LOW_PCT: low_pct <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Breakpoint table; writes past the last entry are dropped
  assign tix_ext = IXW'(table_index);
  assign tix_ok  = (tix_ext < IXW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        bp_mv[i]  <= '0;
        bp_pct[i] <= '0;
      end
    end else if (cmd.load_in && op && tix_ok) begin
      bp_mv[tix_ext[AW-1:0]]  <= table_mv;
      bp_pct[tix_ext[AW-1:0]] <= table_percent;
    end
  end

  // Running sum of converter readings, cleared when an average is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.load_in && !op && measure_enable) begin
      sample_sum   <= sample_sum + SUM_W'(adc_sample);
      sample_count <= sample_count + CNT_W'(1);
    end else if (cmd.avg_start) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mains_r <= mains_lost;
    end
  end

  // Shared 20x12 multiplier: gain halves for the average, slope for a segment
  always_comb begin
    mul_a = sample_sum;
    mul_b = mv_gain[GAIN_HALF_W-1:0];
    if (cmd.mul_hi) begin
      mul_b = mv_gain[GAIN_W-1:GAIN_HALF_W];
    end
    if (cmd.interp_mul) begin
      mul_a = SUM_W'(seg_off);
      mul_b = GAIN_HALF_W'(seg_delta);
    end
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo || cmd.interp_mul) begin
      p0 <= mul_p;
    end
    if (cmd.mul_hi) begin
      p1 <= mul_p;
    end
  end

  // Divider operands: sum times gain >> 16 over SAMPLES, or the segment fraction
  always_comb begin
    avg_prod   = PROD_W'(p0) + {p1, {GAIN_HALF_W{1'b0}}};
    interp_num = p0[NUM_W-1:0] +
                 (seg_up ? {NUM_W{1'b0}} : (NUM_W'(seg_d) - NUM_W'(1)));
    div_start  = cmd.avg_start || cmd.interp_start;
    if (cmd.interp_start) begin
      div_num = interp_num;
      div_den = seg_d;
    end else begin
      div_num = avg_prod[PROD_W-1:FRAC_W];
      div_den = DEN_W'(SAMPLES);
    end
  end

  bcm_div #(
    .NW(NUM_W),
    .DW(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_q)
  );

  // Stored average, saturated to 16 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      average <= '0;
    end else if (cmd.avg_store) begin
      average <= (|div_q[NUM_W-1:MV_W]) ? {MV_W{1'b1}} : div_q[MV_W-1:0];
    end
  end

  // Segment scan: one table entry per cycle, the previous one held
  assign cur_mv  = bp_mv[scan_idx];
  assign cur_pct = bp_pct[scan_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.scan_init) begin
      scan_idx <= AW'(1);
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      prev_mv  <= bp_mv[0];
      prev_pct <= bp_pct[0];
    end else if (cmd.scan_step) begin
      prev_mv  <= cur_mv;
      prev_pct <= cur_pct;
    end
  end

  // Capture the matching segment's offset, span and charge slope
  always_ff @(posedge clk) begin
    if (cmd.seg_latch) begin
      seg_off   <= prev_mv - average;
      seg_d     <= prev_mv - cur_mv;
      seg_c0    <= prev_pct;
      seg_up    <= (cur_pct >= prev_pct);
      seg_delta <= (cur_pct >= prev_pct) ? (cur_pct - prev_pct) : (prev_pct - cur_pct);
    end
  end

  // Interpolated charge; the quotient never exceeds the charge step
  always_comb begin
    if (seg_up) begin
      pct_sum = {1'b0, seg_c0} + {1'b0, div_q[PCT_W-1:0]};
    end else begin
      pct_sum = {1'b0, seg_c0} - {1'b0, div_q[PCT_W-1:0]};
    end
    pct_interp = (pct_sum > {1'b0, PCT_FULL}) ? PCT_FULL : pct_sum[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_full) begin
      pct_r   <= PCT_FULL;
      valid_r <= 1'b1;
    end else if (cmd.set_miss) begin
      pct_r   <= '0;
      valid_r <= 1'b0;
    end else if (cmd.interp_store) begin
      pct_r   <= pct_interp;
      valid_r <= 1'b1;
    end
  end

  // Status for the outgoing word
  always_comb begin
    if (!valid_r || (pct_r <= low_pct)) begin
      st_next = ST_LOW_BATTERY;
    end else if (mains_r) begin
      st_next = ST_ON_BATTERY;
    end else begin
      st_next = ST_ONLINE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= st_next;
      charge_percent <= pct_r;
      charge_valid   <= valid_r;
      average_mv     <= average;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.op_table   = op;
    stat.count_full = (sample_count == CNT_W'(SAMPLES));
    stat.above_full = (average > FULL_CHARGE_MV);
    stat.hit        = (average < prev_mv) && (average > cur_mv);
    stat.scan_last  = (scan_idx == AW'(SEGMENTS));
    stat.div_busy   = div_busy;
  end

endmodule

>>> sv/bcm_ctrl.sv
// Controller state machine: sequences accumulate, average, scan and
// interpolation, and owns the handshakes. Uses bcm_pkg.
`timescale 1ns / 1ps

module bcm_ctrl import bcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  output logic      result_valid,
  input  logic      result_ready,
  input  bcm_stat_t stat,
  output bcm_cmd_t  cmd
);

  bcm_state_t state;
  bcm_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          if (!stat.op_table) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_next = stat.count_full ? S_MUL_LO : S_LOOKUP;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        cmd.avg_start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (!stat.div_busy) begin
          cmd.avg_store = 1'b1;
          state_next    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat.above_full) begin
          cmd.set_full = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.seg_latch = 1'b1;
          state_next    = S_SEG_MUL;
        end else if (stat.scan_last) begin
          cmd.set_miss = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SEG_MUL: begin
        cmd.interp_mul = 1'b1;
        state_next     = S_SEG_DIV;
      end
      S_SEG_DIV: begin
        cmd.interp_start = 1'b1;
        state_next       = S_SEG_WAIT;
      end
      S_SEG_WAIT: begin
        if (!stat.div_busy) begin
          cmd.interp_store = 1'b1;
          state_next       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/battery_charge_monitor_unit.sv
// Battery charge monitor top level. A table write completes in its accept cycle.
// A sample tick above full charge gives its word without a scan; else the table is
// scanned one entry per cycle and a matching segment is interpolated by multiply and
// serial divide. A tick that closes an average first multiplies the sum by the gain
// and divides it. The next item is taken in the cycle after the word is loaded.
// Reset clears the sum, count, average and table, and loads the register defaults.
`timescale 1ns / 1ps

module battery_charge_monitor_unit import bcm_pkg::*; #(
  parameter int SAMPLES  = 16,
  parameter int SEGMENTS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  op,
  input  logic                  mains_lost,
  input  logic                  measure_enable,
  input  logic [ADC_W-1:0]      adc_sample,
  input  logic [IDX_W-1:0]      table_index,
  input  logic [MV_W-1:0]       table_mv,
  input  logic [PCT_W-1:0]      table_percent,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [1:0]            status,
  output logic [PCT_W-1:0]      charge_percent,
  output logic                  charge_valid,
  output logic [MV_W-1:0]       average_mv,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bcm_cmd_t  cmd;
  bcm_stat_t stat;

  bcm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  bcm_dp #(
    .SAMPLES (SAMPLES),
    .SEGMENTS(SEGMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .mains_lost    (mains_lost),
    .measure_enable(measure_enable),
    .adc_sample    (adc_sample),
    .table_index   (table_index),
    .table_mv      (table_mv),
    .table_percent (table_percent),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .charge_percent(charge_percent),
    .charge_valid  (charge_valid),
    .average_mv    (average_mv)
  );

  // A charge outside every segment always reports low battery with zero percent
  a_miss_is_low: assert property (@(posedge clk) disable iff (rst)
    result_valid && !charge_valid |-> status == ST_LOW_BATTERY && charge_percent == '0)
    else $error("invalid charge without low battery status");

  // Reported charge stays within whole percent range
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> charge_percent <= PCT_FULL)
    else $error("charge percent above full");

  // A table write completes in its accept cycle
  a_table_write_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && op |=> item_ready)
    else $error("table write stalled the input");

  // A sample tick always occupies the controller past its accept cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !op |=> !item_ready)
    else $error("sample tick finished without work");

endmodule
